// File: src/pvar_pkg.sv
// ----------------------------------------------------------------------------
// pvar_pkg
// shared types and constants for the per-pixel variance core
// ----------------------------------------------------------------------------
package pvar_pkg;

  localparam int unsigned OUT_W = 64;
  localparam int unsigned PEAK_W = 48;
  localparam int unsigned CFG_W = 5;
  localparam int unsigned NUM_CH = 3;

  localparam logic [OUT_W-1:0] SAT_MAX = {OUT_W{1'b1}};
  localparam logic [PEAK_W-1:0] PEAK_MAX = {PEAK_W{1'b1}};

  localparam logic KIND_PIXEL = 1'b0;
  localparam logic KIND_TOTALS = 1'b1;

  typedef enum logic [6:0] {
    ST_IDLE   = 7'b0000001,
    ST_SQ     = 7'b0000010,
    ST_DIFF   = 7'b0000100,
    ST_DIV    = 7'b0001000,
    ST_ACC    = 7'b0010000,
    ST_OUT    = 7'b0100000,
    ST_TOT    = 7'b1000000
  } state_t;

  function automatic logic [OUT_W-1:0] sat_add(input logic [OUT_W-1:0] a,
                                               input logic [OUT_W-1:0] b);
    logic [OUT_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[OUT_W] ? SAT_MAX : s[OUT_W-1:0];
  endfunction

endpackage

// File: src/pixel_variance_across_runs_core.sv
// ----------------------------------------------------------------------------
// pixel_variance_across_runs_core
// per-pixel unbiased variance and mean across runs, with image totals
// ----------------------------------------------------------------------------
//  channel | ports                              | word
//  in      | in_valid/in_ready, in_sample_*     | one run sample of a pixel
//  out     | out_valid/out_ready, out_*         | pixel result or image totals
//  cfg     | cfg_we/cfg_data                    | run count
//
//  each sample is accepted, then squared once per channel; a final sample
//  adds per channel two serial divisions (mean, then variance), then the
//  pixel result word and, after the image's final pixel, the totals word
//  are sent; rst_n is synchronous
//  totals clear after they are delivered
//  a stalled out channel holds the block until the word is taken
module pixel_variance_across_runs_core #(
  parameter int unsigned MAX_RUNS = 16,
  parameter int unsigned SAMPLE_BITS = 24
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [4:0]  cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [23:0] in_sample_red,
  input  logic [23:0] in_sample_green,
  input  logic [23:0] in_sample_blue,
  input  logic        in_final_pixel,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_kind,
  output logic [63:0] out_var_total,
  output logic [47:0] out_var_peak,
  output logic [63:0] out_mean_total,
  output logic [63:0] out_mean_sq_total,
  output logic [63:0] out_mean_red,
  output logic [63:0] out_mean_green,
  output logic [63:0] out_mean_blue,
  output logic        out_last
);

  localparam int unsigned RUN_W = $clog2(MAX_RUNS + 1);
  localparam int unsigned SUM_W = SAMPLE_BITS + RUN_W;
  localparam int unsigned SQ_W = 2 * SAMPLE_BITS + RUN_W;
  localparam int unsigned NUM_W = 2 * SUM_W + RUN_W + 1;
  localparam int unsigned DEN_W = 2 * RUN_W;
  localparam int unsigned W = pvar_pkg::OUT_W;

  pvar_pkg::state_t state_r, state_nxt;

  logic [4:0]             rc_r;
  logic [RUN_W-1:0]       k_eff, n_r, cnt_r;
  logic [1:0]             ch_r;
  logic [SAMPLE_BITS-1:0] smp_r [3];
  logic [SUM_W-1:0]       sum_r [3];
  logic [SQ_W-1:0]        sq_r [3];
  logic                   fin_r;

  // shared multiplier
  logic [SUM_W-1:0]   mul_a;
  logic [2*SUM_W-1:0] mul_p;
  logic [2*SUM_W-1:0] prod_r;
  assign mul_p = mul_a * mul_a;

  logic [NUM_W-1:0] dnum;
  logic [DEN_W-1:0] dden;
  logic             dstart, ddone, dmode_r;
  logic [NUM_W-1:0] dq;

  pvar_div #(.NUM_W(NUM_W), .DEN_W(DEN_W)) u_div (
    .clk(clk), .rst_n(rst_n), .start(dstart), .num(dnum), .den(dden),
    .done(ddone), .quo(dq)
  );

  logic [W-1:0] mean_r [3];
  logic [W-1:0] var_r [3];
  logic [W-1:0] img_vs_r, img_ms_r, img_mq_r, img_cm_r [3];
  logic [pvar_pkg::PEAK_W-1:0] img_pk_r;
  logic [W-1:0] vs, vpk, ms;

  always_comb begin
    k_eff = (rc_r < 5'd2) ? RUN_W'(2) :
            (32'(rc_r) > MAX_RUNS) ? RUN_W'(MAX_RUNS) : RUN_W'(rc_r);
  end

  always_comb begin
    mul_a = '0;
    unique case (state_r)
      pvar_pkg::ST_SQ: mul_a = SUM_W'(smp_r[ch_r]);
      pvar_pkg::ST_ACC: mul_a = SUM_W'(mean_r[ch_r][SAMPLE_BITS-1:0]);
      default: mul_a = sum_r[ch_r];
    endcase
  end

  // final stats, combined over three channels
  always_comb begin
    vs = '0; vpk = '0; ms = '0;
    for (int c = 0; c < 3; c++) begin
      vs = pvar_pkg::sat_add(vs, var_r[c]);
      if (var_r[c] > vpk) vpk = var_r[c];
      ms = pvar_pkg::sat_add(ms, mean_r[c]);
    end
  end

  logic [NUM_W-1:0] diff;
  assign diff = NUM_W'(sq_r[ch_r]) * NUM_W'(n_r) - NUM_W'(prod_r);
  logic [NUM_W+W-1:0] dq_x;
  assign dq_x = {{W{1'b0}}, dq};
  logic [W-1:0] qsat;
  assign qsat = (dq_x[NUM_W+W-1:W] != '0) ? pvar_pkg::SAT_MAX : dq_x[W-1:0];

  logic [W-1:0] mq_r;

  always_comb begin
    state_nxt = state_r;
    dstart = 1'b0;
    dnum = '0;
    dden = '0;
    unique case (state_r)
      pvar_pkg::ST_IDLE: if (in_valid) state_nxt = pvar_pkg::ST_SQ;
      pvar_pkg::ST_SQ: begin
        if (ch_r == 2'd2) begin
          if (cnt_r + 1'b1 >= k_eff) state_nxt = pvar_pkg::ST_DIFF;
          else state_nxt = pvar_pkg::ST_IDLE;
        end
      end
      pvar_pkg::ST_DIFF: begin
        // sum^2 lands in prod_r, mean division starts
        state_nxt = pvar_pkg::ST_DIV;
      end
      pvar_pkg::ST_DIV: begin
        if (!dmode_r && ddone) state_nxt = pvar_pkg::ST_DIV;
        else if (dmode_r && ddone) state_nxt = pvar_pkg::ST_ACC;
      end
      pvar_pkg::ST_ACC: state_nxt = (ch_r == 2'd2) ? pvar_pkg::ST_OUT : pvar_pkg::ST_DIFF;
      pvar_pkg::ST_OUT: if (out_ready)
        state_nxt = fin_r ? pvar_pkg::ST_TOT : pvar_pkg::ST_IDLE;
      pvar_pkg::ST_TOT: if (out_ready) state_nxt = pvar_pkg::ST_IDLE;
      default: state_nxt = pvar_pkg::ST_IDLE;
    endcase
    if (state_r == pvar_pkg::ST_DIFF) begin
      dstart = 1'b1;
      dnum = NUM_W'(sum_r[ch_r]);
      dden = DEN_W'(n_r);
    end else if (state_r == pvar_pkg::ST_DIV && !dmode_r && ddone) begin
      dstart = 1'b1;
      dnum = diff;
      dden = DEN_W'(n_r) * DEN_W'(n_r - 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= pvar_pkg::ST_IDLE;
      rc_r <= 5'd2;
      cnt_r <= '0;
      ch_r <= '0;
      dmode_r <= 1'b0;
      for (int c = 0; c < 3; c++) begin
        sum_r[c] <= '0;
        sq_r[c] <= '0;
        img_cm_r[c] <= '0;
      end
      img_vs_r <= '0;
      img_ms_r <= '0;
      img_mq_r <= '0;
      img_pk_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) rc_r <= cfg_data;
      unique case (state_r)
        pvar_pkg::ST_IDLE: if (in_valid) begin
          smp_r[0] <= SAMPLE_BITS'(in_sample_red);
          smp_r[1] <= SAMPLE_BITS'(in_sample_green);
          smp_r[2] <= SAMPLE_BITS'(in_sample_blue);
          fin_r <= in_final_pixel;
          ch_r <= '0;
        end
        pvar_pkg::ST_SQ: begin
          sum_r[ch_r] <= sum_r[ch_r] + SUM_W'(smp_r[ch_r]);
          sq_r[ch_r] <= sq_r[ch_r] + SQ_W'(mul_p);
          if (ch_r == 2'd2) begin
            ch_r <= '0;
            if (cnt_r + 1'b1 >= k_eff) begin
              n_r <= cnt_r + 1'b1;
              cnt_r <= '0;
            end else cnt_r <= cnt_r + 1'b1;
          end else ch_r <= ch_r + 1'b1;
        end
        pvar_pkg::ST_DIFF: begin
          prod_r <= mul_p;
          dmode_r <= 1'b0;
        end
        pvar_pkg::ST_DIV: if (ddone) begin
          if (!dmode_r) begin
            mean_r[ch_r] <= qsat;
            dmode_r <= 1'b1;
          end else var_r[ch_r] <= qsat;
        end
        pvar_pkg::ST_ACC: begin
          sum_r[ch_r] <= '0;
          sq_r[ch_r] <= '0;
          ch_r <= (ch_r == 2'd2) ? 2'd0 : ch_r + 1'b1;
        end
        pvar_pkg::ST_OUT: if (out_ready) begin
          img_vs_r <= pvar_pkg::sat_add(img_vs_r, vs);
          if (vpk[W-1:pvar_pkg::PEAK_W] != '0) img_pk_r <= pvar_pkg::PEAK_MAX;
          else if (vpk[pvar_pkg::PEAK_W-1:0] > img_pk_r)
            img_pk_r <= vpk[pvar_pkg::PEAK_W-1:0];
          img_ms_r <= pvar_pkg::sat_add(img_ms_r, ms);
          img_mq_r <= pvar_pkg::sat_add(img_mq_r, mq_r);
          for (int c = 0; c < 3; c++)
            img_cm_r[c] <= pvar_pkg::sat_add(img_cm_r[c], mean_r[c]);
        end
        pvar_pkg::ST_TOT: if (out_ready) begin
          img_vs_r <= '0;
          img_ms_r <= '0;
          img_mq_r <= '0;
          img_pk_r <= '0;
          for (int c = 0; c < 3; c++) img_cm_r[c] <= '0;
        end
        default: ;
      endcase
    end
  end

  // squared means through the shared multiplier
  logic [W-1:0] msq_sum;
  assign msq_sum = pvar_pkg::sat_add(mq_r, W'(mul_p));

  always_ff @(posedge clk) begin
    if (state_r == pvar_pkg::ST_DIFF && ch_r == 2'd0) mq_r <= '0;
    else if (state_r == pvar_pkg::ST_ACC) mq_r <= msq_sum;
  end

  wire is_tot = (state_r == pvar_pkg::ST_TOT);
  assign in_ready = (state_r == pvar_pkg::ST_IDLE);
  assign out_valid = (state_r == pvar_pkg::ST_OUT) || is_tot;
  assign out_kind = is_tot ? pvar_pkg::KIND_TOTALS : pvar_pkg::KIND_PIXEL;
  assign out_var_total = is_tot ? img_vs_r : vs;
  assign out_var_peak = is_tot ? img_pk_r : vpk[pvar_pkg::PEAK_W-1:0];
  assign out_mean_total = is_tot ? img_ms_r : ms;
  assign out_mean_sq_total = is_tot ? img_mq_r : mq_r;
  assign out_mean_red = is_tot ? img_cm_r[0] : mean_r[0];
  assign out_mean_green = is_tot ? img_cm_r[1] : mean_r[1];
  assign out_mean_blue = is_tot ? img_cm_r[2] : mean_r[2];
  assign out_last = is_tot ? 1'b1 : !fin_r;

  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid)) else $error("ready during output");
  a_tot_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == pvar_pkg::ST_OUT && out_ready && fin_r) |=> out_valid && out_kind)
    else $error("totals missing");
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r < RUN_W'(MAX_RUNS)) else $error("run count overflow");

endmodule

// File: src/pvar_div.sv
// ----------------------------------------------------------------------------
// pvar_div
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module pvar_div #(
  parameter int unsigned NUM_W = 128,
  parameter int unsigned DEN_W = 16
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             done,
  output logic [NUM_W-1:0] quo
);

  localparam int unsigned CNT_W = $clog2(NUM_W + 1);

  logic [NUM_W-1:0] q_r, q_nxt, q_step;
  logic [DEN_W-1:0] rem_r, rem_nxt, rem_step;
  logic [DEN_W-1:0] den_r, den_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt;
  logic [DEN_W:0]   trial;
  logic             fits;

  always_comb begin
    trial = {rem_r, q_r[NUM_W-1]};
    fits = (trial >= {1'b0, den_r});
    q_step = {q_r[NUM_W-2:0], fits};
    rem_step = fits ? DEN_W'(trial - {1'b0, den_r}) : trial[DEN_W-1:0];
    q_nxt = q_r;
    rem_nxt = rem_r;
    den_nxt = den_r;
    cnt_nxt = cnt_r;
    busy_nxt = busy_r;
    if (start) begin
      q_nxt = num;
      rem_nxt = '0;
      den_nxt = den;
      cnt_nxt = CNT_W'(NUM_W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      q_nxt = q_step;
      rem_nxt = rem_step;
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CNT_W'(1)) busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    q_r <= q_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  assign done = busy_r && (cnt_r == CNT_W'(1));
  assign quo = q_step;

endmodule
